>>> hdl/matrix_vector_transform_4x4_defines.svh
// ----------------------------------------------------------------------------
// matrix_vector_transform_4x4 assertion macros
// shared property forms for the transform block; the host module supplies
// clk and arst_n
// ----------------------------------------------------------------------------
`ifndef MATRIX_VECTOR_TRANSFORM_4X4_DEFINES_SVH
`define MATRIX_VECTOR_TRANSFORM_4X4_DEFINES_SVH

// consequent must hold in the same cycle as the antecedent
`define MVT_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// consequent must hold in the cycle after the antecedent
`define MVT_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> hdl/mvt_pkg.sv
// ----------------------------------------------------------------------------
// mvt_pkg
// widths, types and request codes of the 4x4 matrix-vector transform
// ----------------------------------------------------------------------------
package mvt_pkg;

	localparam int DATA_W    = 32;
	localparam int FRAC_BITS = 16;
	localparam int VEC_N     = 4;
	localparam int ENTRIES   = VEC_N * VEC_N;
	localparam int IDX_W     = $clog2(ENTRIES);
	localparam int TYPE_W    = 2;
	// product after the fraction shift, and a row sum of VEC_N of them
	localparam int PROD_W    = 2 * DATA_W - FRAC_BITS;
	localparam int SUM_W     = PROD_W + $clog2(VEC_N);

	typedef logic signed [DATA_W-1:0] word_t;
	typedef logic signed [PROD_W-1:0] prod_t;
	typedef logic signed [SUM_W-1:0]  sum_t;
	typedef logic [IDX_W-1:0]         idx_t;
	typedef word_t [ENTRIES-1:0]      mat_t;

	typedef enum logic [TYPE_W-1:0] {
		REQ_LOAD   = 2'd0,
		REQ_POINT  = 2'd1,
		REQ_VECTOR = 2'd2
	} req_type_t;

	localparam word_t WORD_MAX = {1'b0, {(DATA_W-1){1'b1}}};
	localparam word_t WORD_MIN = {1'b1, {(DATA_W-1){1'b0}}};
	localparam word_t Q_ONE    = word_t'(1) << FRAC_BITS;

	typedef struct packed {
		logic  en;
		idx_t  idx;
		word_t data;
	} mat_wr_t;

endpackage

>>> hdl/mvt_req_if.sv
// ----------------------------------------------------------------------------
// mvt_req_if
// request channel: matrix entry loads and vector transforms
// ----------------------------------------------------------------------------
interface mvt_req_if;
	import mvt_pkg::*;

	logic                valid;
	logic                ready;
	logic [TYPE_W-1:0]   req_type;
	logic [IDX_W-1:0]    entry_index;
	logic signed [DATA_W-1:0] in_x;
	logic signed [DATA_W-1:0] in_y;
	logic signed [DATA_W-1:0] in_z;
	logic signed [DATA_W-1:0] in_w;

	modport source (
		output valid, req_type, entry_index, in_x, in_y, in_z, in_w,
		input  ready
	);
	modport sink (
		input  valid, req_type, entry_index, in_x, in_y, in_z, in_w,
		output ready
	);
endinterface

>>> hdl/mvt_res_if.sv
// ----------------------------------------------------------------------------
// mvt_res_if
// result channel: transformed vector and saturation flag
// ----------------------------------------------------------------------------
interface mvt_res_if;
	import mvt_pkg::*;

	logic                     valid;
	logic                     ready;
	logic signed [DATA_W-1:0] out_x;
	logic signed [DATA_W-1:0] out_y;
	logic signed [DATA_W-1:0] out_z;
	logic signed [DATA_W-1:0] out_w;
	logic                     overflow;

	modport source (
		output valid, out_x, out_y, out_z, out_w, overflow,
		input  ready
	);
	modport sink (
		input  valid, out_x, out_y, out_z, out_w, overflow,
		output ready
	);
endinterface

>>> hdl/matrix_vector_transform_4x4.sv
// ----------------------------------------------------------------------------
// matrix_vector_transform_4x4
// Signed Q16.16 4x4 matrix times vector. Load requests write one matrix entry
// (cleared to zero at reset) and give no result; point requests transform
// (x, y, z, 1) through rows 0..2 with out_w zero, vector requests transform
// (x, y, z, w) through all four rows. Each product is shifted right by the
// fraction bits, row sums saturate to 32 bits and set overflow. The block
// takes one request per cycle while the result channel is not stalled. Each
// transform passes the input register, sixteen parallel multiplier lanes into
// a product register, then row adders and saturation into the result register.
// A load takes effect for every request that follows it.
// ----------------------------------------------------------------------------
`include "matrix_vector_transform_4x4_defines.svh"

module matrix_vector_transform_4x4 (
	input logic       clk,
	input logic       arst_n,
	mvt_req_if.sink   req,
	mvt_res_if.source res
);
	import mvt_pkg::*;

	// stage advance enables, back to front
	logic adv1, adv2, adv3;

	// input stage
	logic              valid_s1;
	logic [TYPE_W-1:0] type_s1;
	idx_t              idx_s1;
	word_t             vec_s1 [VEC_N];

	// product stage
	logic  valid_s2;
	logic  point_s2;
	prod_t prod_s2 [VEC_N][VEC_N];

	// result register
	logic  res_valid_q;
	word_t out_q [VEC_N];
	logic  ovf_q;

	mat_t    mat;
	mat_wr_t mat_wr;
	prod_t   prod_d [VEC_N][VEC_N];
	word_t   row_val [VEC_N];
	logic    row_sat [VEC_N];
	logic    is_xform_s1;

	assign adv3 = !res_valid_q || res.ready;
	assign adv2 = !valid_s2 || adv3;
	assign adv1 = !valid_s1 || adv2;
	assign req.ready = adv1;

	assign is_xform_s1 = (type_s1 == REQ_POINT) || (type_s1 == REQ_VECTOR);

	// ---------------- input stage ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv1) begin
			valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && adv1) begin
			type_s1   <= req.req_type;
			idx_s1    <= req.entry_index;
			vec_s1[0] <= req.in_x;
			vec_s1[1] <= req.in_y;
			vec_s1[2] <= req.in_z;
			// w = 1 makes column 3 the translation, exactly
			vec_s1[3] <= (req.req_type == REQ_POINT) ? Q_ONE : req.in_w;
		end
	end

	// load writes as it leaves the input stage, so it orders with transforms
	always_comb begin
		mat_wr.en   = valid_s1 && (type_s1 == REQ_LOAD) && adv2;
		mat_wr.idx  = idx_s1;
		mat_wr.data = vec_s1[0];
	end

	mvt_matrix u_matrix (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (mat_wr),
		.entries (mat)
	);

	// ---------------- multiplier lanes ----------------
	for (genvar r = 0; r < VEC_N; r++) begin : g_row
		for (genvar c = 0; c < VEC_N; c++) begin : g_col
			logic signed [2*DATA_W-1:0] full;

			assign full = mat[r*VEC_N+c] * vec_s1[c];
			assign prod_d[r][c] = full[2*DATA_W-1:FRAC_BITS];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv2) begin
			valid_s2 <= valid_s1 && is_xform_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv2) begin
			point_s2 <= (type_s1 == REQ_POINT);
			prod_s2  <= prod_d;
		end
	end

	// ---------------- row sums and saturation ----------------
	for (genvar r = 0; r < VEC_N; r++) begin : g_sum
		mvt_row_sat u_row (
			.prod  (prod_s2[r]),
			.value (row_val[r]),
			.sat   (row_sat[r])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (adv3) begin
			res_valid_q <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv3 && valid_s2) begin
			out_q[0] <= row_val[0];
			out_q[1] <= row_val[1];
			out_q[2] <= row_val[2];
			// row 3 is unused for points and cannot flag overflow
			out_q[3] <= point_s2 ? '0 : row_val[3];
			ovf_q    <= row_sat[0] || row_sat[1] || row_sat[2]
				|| (!point_s2 && row_sat[3]);
		end
	end

	assign res.valid    = res_valid_q;
	assign res.out_x    = out_q[0];
	assign res.out_y    = out_q[1];
	assign res.out_z    = out_q[2];
	assign res.out_w    = out_q[3];
	assign res.overflow = ovf_q;

	`MVT_ASSERT_NEXT(a_load_no_result, valid_s1 && !is_xform_s1 && adv2, !valid_s2, "load or unused request reached products")
	`MVT_ASSERT_NEXT(a_point_w_zero, adv3 && valid_s2 && point_s2, res.out_w == '0, "point result with nonzero w")
	`MVT_ASSERT_NEXT(a_product_moves, adv3 && valid_s2, res_valid_q, "product stage item dropped")
	`MVT_ASSERT_SAME(a_ready_when_empty, !valid_s1, req.ready, "input stalled while empty")

endmodule

>>> hdl/mvt_matrix.sv
// ----------------------------------------------------------------------------
// mvt_matrix
// row-major 4x4 coefficient registers, cleared at reset, one entry written
// per load
// ----------------------------------------------------------------------------
`include "matrix_vector_transform_4x4_defines.svh"

module mvt_matrix (
	input  logic             clk,
	input  logic             arst_n,
	input  mvt_pkg::mat_wr_t wr,
	output mvt_pkg::mat_t    entries
);
	import mvt_pkg::*;

	mat_t entries_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entries_q <= '0;
		end else if (wr.en) begin
			entries_q[wr.idx] <= wr.data;
		end
	end

	assign entries = entries_q;

	`MVT_ASSERT_NEXT(a_wr_lands, wr.en, entries_q[$past(wr.idx)] == $past(wr.data), "matrix write lost")
	`MVT_ASSERT_NEXT(a_no_wr_hold, !wr.en, $stable(entries_q), "matrix changed without a write")

endmodule

>>> hdl/mvt_row_sat.sv
// ----------------------------------------------------------------------------
// mvt_row_sat
// one row: exact sum of the shifted products, saturated to a 32-bit word
// ----------------------------------------------------------------------------
module mvt_row_sat (
	input  mvt_pkg::prod_t prod [mvt_pkg::VEC_N],
	output mvt_pkg::word_t value,
	output logic           sat
);
	import mvt_pkg::*;

	sum_t sum;
	logic fits;

	always_comb begin
		sum = '0;
		for (int c = 0; c < VEC_N; c++) begin
			sum = sum + sum_t'(prod[c]);
		end
	end

	// in range when every bit above the word's sign bit copies it
	assign fits = (&sum[SUM_W-1:DATA_W-1]) || !(|sum[SUM_W-1:DATA_W-1]);

	always_comb begin
		sat = !fits;
		if (fits) begin
			value = sum[DATA_W-1:0];
		end else if (sum[SUM_W-1]) begin
			value = WORD_MIN;
		end else begin
			value = WORD_MAX;
		end
	end

endmodule
